// ----- rtl/core/mdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mdt_pkg;

    localparam int DEF_NUM_IDS     = 1024;
    localparam int DEF_NUM_CLIENTS = 16;

    localparam int OP_W  = 3;
    localparam int MID_W = 10;
    localparam int CID_W = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // entry layout: flags, owner, then one membership bit per client
    localparam int FL_STORED  = 0;
    localparam int FL_UNDELIV = 1;
    localparam int FL_COMMIT  = 2;
    localparam int FL_OWNED   = 3;
    localparam int OWN_LSB    = 4;
    localparam int MEMB_LSB   = OWN_LSB + CID_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_COMMIT     = 3'd1,
        OP_DELIVER    = 3'd2,
        OP_DISCONNECT = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr;
        logic scan;
        logic fetch;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic dc_go;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/core/message_delivery_tracker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  beat fields (tdata, low bit first)
// s_axis    in   op[2:0] msg_id[12:3] cons_id[16:13], zero pad to 24
// m_axis    out  status[0] is_stored[1] is_undelivered[2] is_committed[3]
//                has_owner[4] owner_client[8:5], zero pad to 16
//
// Insert, commit, deliver, query and a failing disconnect: one table read
// then one write with the result registered.
// A disconnect that succeeds scans every id.
// After reset the table is cleared one entry a cycle, tready low.
// A held result lets one more beat in; it waits before its write-back, tready low.

module message_delivery_tracker_top
    import mdt_pkg::*;
#(
    parameter int NUM_IDS     = DEF_NUM_IDS,
    parameter int NUM_CLIENTS = DEF_NUM_CLIENTS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // op, msg_id, cons_id
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // status, stored, undelivered, committed, has_owner, owner_client
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (w_sts),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    mdt_dp #(
        .NUM_IDS     (NUM_IDS),
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_s_tdata (i_s_axis_tdata),
        .o_sts     (w_sts),
        .o_m_tdata (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/mdt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mdt_ctrl
    import mdt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire logic    i_m_tready,
    input  wire t_dp_sts i_sts,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   w_out_free;

    assign w_out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) n_state = i_sts.dc_go ? S_SCAN : S_RESULT;
            end
            S_SCAN: begin
                if (i_sts.last) n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_FETCH;
            S_FETCH:  n_state = S_RESULT;
            S_RESULT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.clr    = (r_state == S_CLEAR);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.fetch  = (r_state == S_FETCH);
        o_cmd.commit = (r_state == S_RESULT) && w_out_free;
        o_s_tready   = (r_state == S_IDLE);
        o_m_tvalid   = r_out_vld;
        n_out_vld    = o_cmd.commit || (r_out_vld && !i_m_tready);
    end

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_vld || i_m_tready))
        else $error("result loaded over an untaken beat");
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.last) |=> (r_state == S_DRAIN))
        else $error("scan did not end at last id");
    a_dc_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.dc_go) |=> (r_state == S_SCAN))
        else $error("disconnect did not start a scan");
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR && !r_out_vld))
        else $error("reset did not start clear pass");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/mdt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mdt_dp
    import mdt_pkg::*;
#(
    parameter int NUM_IDS     = DEF_NUM_IDS,
    parameter int NUM_CLIENTS = DEF_NUM_CLIENTS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    output t_dp_sts                     o_sts,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata
);

    localparam int IW    = $clog2(NUM_IDS);
    localparam int EW    = MEMB_LSB + NUM_CLIENTS;
    localparam int IDX_W = 17;
    localparam int CLX_W = 7;
    localparam logic [IW-1:0] LAST_ADDR = IW'(NUM_IDS - 1);

    logic [EW-1:0] r_mem [NUM_IDS];
    logic [EW-1:0] r_rdata;

    t_op              r_op;
    logic [MID_W-1:0] r_id;
    logic [CID_W-1:0] r_cl;
    logic             r_dc_ok;
    logic [IW-1:0]    r_cnt;
    logic             r_wb_vld;
    logic [IW-1:0]    r_wb_addr;
    logic [NUM_CLIENTS-1:0] r_known;
    logic [OUT_TDATA_W-1:0] r_out;

    logic [OP_W-1:0]  w_in_op;
    logic [MID_W-1:0] w_in_id;
    logic [CID_W-1:0] w_in_cl;
    logic [IDX_W-1:0] w_in_idx;
    logic [IDX_W-1:0] w_r_idx;
    logic             w_in_cl_ok;
    logic [NUM_CLIENTS-1:0] w_in_mask;
    logic [NUM_CLIENTS-1:0] w_cl_mask;
    logic [NUM_CLIENTS-1:0] w_own_mask;
    logic             w_id_ok;
    logic             w_cl_ok;
    logic             w_rd_en;
    logic [IW-1:0]    w_rd_addr;
    logic             w_wr_en;
    logic [IW-1:0]    w_wr_addr;
    logic [EW-1:0]    w_wr_data;
    logic [EW-1:0]    w_scan_ent;
    logic [EW-1:0]    w_new;
    logic             w_fail;
    logic             w_upd;
    logic [OUT_TDATA_W-1:0] w_out;

    assign w_in_op   = i_s_tdata[OP_W-1:0];
    assign w_in_id   = i_s_tdata[OP_W+MID_W-1:OP_W];
    assign w_in_cl   = i_s_tdata[OP_W+MID_W+CID_W-1:OP_W+MID_W];
    assign w_in_idx  = {{(IDX_W-MID_W){1'b0}}, w_in_id};
    assign w_r_idx   = {{(IDX_W-MID_W){1'b0}}, r_id};
    assign w_in_cl_ok = {{(CLX_W-CID_W){1'b0}}, w_in_cl} < CLX_W'(NUM_CLIENTS);
    assign w_in_mask = NUM_CLIENTS'(1) << w_in_cl;
    assign w_cl_mask = NUM_CLIENTS'(1) << r_cl;
    assign w_own_mask = NUM_CLIENTS'(1) << r_rdata[OWN_LSB+CID_W-1:OWN_LSB];
    assign w_id_ok   = w_r_idx < IDX_W'(NUM_IDS);
    assign w_cl_ok   = {{(CLX_W-CID_W){1'b0}}, r_cl} < CLX_W'(NUM_CLIENTS);

    assign o_sts.last  = (r_cnt == LAST_ADDR);
    assign o_sts.dc_go = (t_op'(w_in_op) == OP_DISCONNECT) && w_in_cl_ok
                         && |(r_known & w_in_mask);

    // read side
    always_comb begin
        w_rd_en = i_cmd.accept || i_cmd.scan || i_cmd.fetch;
        priority if (i_cmd.scan) begin
            w_rd_addr = r_cnt;
        end else if (i_cmd.fetch) begin
            w_rd_addr = w_r_idx[IW-1:0];
        end else begin
            w_rd_addr = w_in_idx[IW-1:0];
        end
    end

    // requeue of one member during a disconnect scan
    always_comb begin
        w_scan_ent = r_rdata;
        w_scan_ent[EW-1:MEMB_LSB] = r_rdata[EW-1:MEMB_LSB] & ~w_cl_mask;
        w_scan_ent[FL_UNDELIV] = 1'b1;
        w_scan_ent[FL_OWNED]   = 1'b0;
        w_scan_ent[OWN_LSB+CID_W-1:OWN_LSB] = '0;
    end

    // operation on the fetched entry
    always_comb begin
        w_new  = r_rdata;
        w_fail = 1'b1;
        w_upd  = 1'b0;
        unique case (r_op)
            OP_INSERT: begin
                w_fail = !w_id_ok || r_rdata[FL_STORED];
                w_new[FL_STORED]  = 1'b1;
                w_new[FL_UNDELIV] = 1'b1;
                w_upd = !w_fail;
            end
            OP_COMMIT: begin
                w_fail = !w_id_ok || !r_rdata[FL_STORED];
                if (r_rdata[FL_OWNED]) begin
                    w_new[EW-1:MEMB_LSB] = r_rdata[EW-1:MEMB_LSB] & ~w_own_mask;
                    w_new[FL_OWNED] = 1'b0;
                    w_new[OWN_LSB+CID_W-1:OWN_LSB] = '0;
                end
                w_new[FL_COMMIT]  = 1'b1;
                w_new[FL_UNDELIV] = 1'b0;
                w_upd = !w_fail;
            end
            OP_DELIVER: begin
                w_fail = !w_id_ok || !w_cl_ok;
                w_new[FL_UNDELIV] = 1'b0;
                w_new[FL_OWNED]   = 1'b1;
                w_new[OWN_LSB+CID_W-1:OWN_LSB] = r_cl;
                w_new[EW-1:MEMB_LSB] = r_rdata[EW-1:MEMB_LSB] | w_cl_mask;
                w_upd = !w_fail;
            end
            OP_DISCONNECT: w_fail = !r_dc_ok;
            OP_QUERY:      w_fail = !w_id_ok;
            default:       w_fail = 1'b1;
        endcase
        if (!w_upd) w_new = r_rdata;
    end

    always_comb begin
        w_out = '0;
        w_out[0] = w_fail;
        if (w_id_ok) begin
            w_out[1] = w_new[FL_STORED];
            w_out[2] = w_new[FL_UNDELIV];
            w_out[3] = w_new[FL_COMMIT];
            w_out[4] = w_new[FL_OWNED];
            if (w_new[FL_OWNED]) w_out[8:5] = w_new[OWN_LSB+CID_W-1:OWN_LSB];
        end
    end

    // write side
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cnt;
        w_wr_data = '0;
        priority if (i_cmd.clr) begin
            w_wr_en = 1'b1;
        end else if (r_wb_vld) begin
            w_wr_en   = |(r_rdata[EW-1:MEMB_LSB] & w_cl_mask);
            w_wr_addr = r_wb_addr;
            w_wr_data = w_scan_ent;
        end else if (i_cmd.commit) begin
            w_wr_en   = w_upd;
            w_wr_addr = w_r_idx[IW-1:0];
            w_wr_data = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) r_rdata <= r_mem[w_rd_addr];
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_wb_vld <= 1'b0;
            r_known  <= '0;
        end else begin
            r_wb_vld <= i_cmd.scan;
            if (i_cmd.clr || i_cmd.scan) r_cnt <= o_sts.last ? '0 : r_cnt + 1'b1;
            if (i_cmd.commit) begin
                if (r_op == OP_DELIVER && !w_fail) r_known <= r_known | w_cl_mask;
                if (r_op == OP_DISCONNECT && !w_fail) r_known <= r_known & ~w_cl_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= r_cnt;
        if (i_cmd.accept) begin
            r_op    <= t_op'(w_in_op);
            r_id    <= w_in_id;
            r_cl    <= w_in_cl;
            r_dc_ok <= o_sts.dc_go;
        end
        if (i_cmd.commit) r_out <= w_out;
    end

    assign o_m_tdata = r_out;

endmodule

`default_nettype wire

// ----- tb/message_delivery_tracker_top_tb.sv -----
`timescale 1ns / 1ps

module message_delivery_tracker_top_tb;
    import mdt_pkg::*;

    localparam int N_IDS     = DEF_NUM_IDS;
    localparam int N_CLIENTS = DEF_NUM_CLIENTS;
    localparam int STALL_LIMIT = 8000;
    localparam int LONG_HOLD   = 400;

    // op codes the block does not define
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [MID_W-1:0] mid;
        logic [CID_W-1:0] cid;
    } t_req;

    typedef struct packed {
        logic             status;
        logic             stored;
        logic             undeliv;
        logic             committed;
        logic             owned;
        logic [CID_W-1:0] owner;
    } t_entry_view;

    typedef struct packed {
        logic                 stored;
        logic                 undeliv;
        logic                 committed;
        logic                 owned;
        logic [CID_W-1:0]     owner;
        logic [N_CLIENTS-1:0] members;
    } t_msg_entry;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // op, msg_id, cons_id
    logic                   m_tvalid;
    logic                   m_tready;
    // status, stored, undelivered, committed, has_owner, owner_client
    logic [OUT_TDATA_W-1:0] m_tdata;

    message_delivery_tracker_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    t_msg_entry  msg_tbl [N_IDS];
    logic        client_known [N_CLIENTS];
    t_req        pending_reqs [$];
    t_entry_view expected_views [$];
    logic [MID_W-1:0] id_pool [16];

    int  src_idle_pct;
    int  snk_idle_pct;
    bit  hold_req;
    int  hold_left;
    bit  in_taken;
    int  quiet_cycles;
    int  mismatches;
    int  results_seen;
    int  fails_seen;
    int  op_count [8];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tracker state after each op; returns the entry view of the op's id
    function automatic t_entry_view track_op(input logic [OP_W-1:0] op,
                                             input logic [MID_W-1:0] mid,
                                             input logic [CID_W-1:0] cid);
        t_entry_view r;
        t_msg_entry  e;
        r = '0;
        e = msg_tbl[mid];
        case (op)
            OP_INSERT: begin
                if (e.stored) begin
                    r.status = 1'b1;
                end else begin
                    e.stored  = 1'b1;
                    e.undeliv = 1'b1;
                end
            end
            OP_COMMIT: begin
                if (!e.stored) begin
                    r.status = 1'b1;
                end else begin
                    if (e.owned) begin
                        e.members[e.owner] = 1'b0;
                        e.owned = 1'b0;
                        e.owner = '0;
                    end
                    e.committed = 1'b1;
                    e.undeliv   = 1'b0;
                end
            end
            OP_DELIVER: begin
                e.undeliv        = 1'b0;
                e.owned          = 1'b1;
                e.owner          = cid;
                e.members[cid]   = 1'b1;
                client_known[cid] = 1'b1;
            end
            OP_DISCONNECT: begin
                if (!client_known[cid]) begin
                    r.status = 1'b1;
                end else begin
                    for (int i = 0; i < N_IDS; i++) begin
                        if (msg_tbl[i].members[cid]) begin
                            msg_tbl[i].members[cid] = 1'b0;
                            msg_tbl[i].undeliv = 1'b1;
                            msg_tbl[i].owned   = 1'b0;
                            msg_tbl[i].owner   = '0;
                        end
                    end
                    client_known[cid] = 1'b0;
                    e = msg_tbl[mid];
                end
            end
            OP_QUERY: ;
            default: r.status = 1'b1;
        endcase
        msg_tbl[mid]  = e;
        r.stored    = e.stored;
        r.undeliv   = e.undeliv;
        r.committed = e.committed;
        r.owned     = e.owned;
        r.owner     = e.owned ? e.owner : '0;
        return r;
    endfunction

    task automatic add(input logic [OP_W-1:0] op, input logic [MID_W-1:0] mid,
                       input logic [CID_W-1:0] cid);
        t_req q;
        q.op  = op;
        q.mid = mid;
        q.cid = cid;
        pending_reqs.push_back(q);
    endtask

    // mostly insert/deliver/retire lifecycles on a small id pool, plus noise
    task automatic queue_traffic(input int n);
        int added;
        int pick;
        logic [MID_W-1:0] mid;
        logic [CID_W-1:0] cid;
        added = 0;
        for (int k = 0; k < 16; k++) id_pool[k] = MID_W'($urandom_range(N_IDS - 1));
        while (added < n) begin
            mid = ($urandom_range(3) == 0) ? MID_W'($urandom_range(N_IDS - 1))
                                           : id_pool[$urandom_range(15)];
            cid = CID_W'($urandom_range(N_CLIENTS - 1));
            if ($urandom_range(99) < 65) begin
                add(OP_INSERT, mid, cid);
                add(OP_DELIVER, mid, cid);
                added += 2;
                if ($urandom_range(2) == 0) begin
                    add(OP_DELIVER, mid, CID_W'($urandom_range(N_CLIENTS - 1)));
                    added++;
                end
                pick = $urandom_range(2);
                if (pick == 0)
                    add(OP_COMMIT, mid, cid);
                else if (pick == 1)
                    add(OP_DISCONNECT, mid, cid);
                else
                    add(OP_DELIVER, id_pool[$urandom_range(15)], cid);
                add(OP_QUERY, mid, cid);
                added += 2;
            end else begin
                add(OP_W'($urandom_range(7)), mid, cid);
                added++;
            end
        end
    endtask

    task automatic wait_all_done();
        while (pending_reqs.size() != 0 || s_tvalid || expected_views.size() != 0)
            @(posedge clk);
    endtask

    // sender
    always @(negedge clk) begin
        t_req q;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_reqs.size() == 0 || $urandom_range(99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                q = pending_reqs.pop_front();
                s_tdata  <= {{(IN_TDATA_W - OP_W - MID_W - CID_W){1'b0}},
                             q.cid, q.mid, q.op};
                s_tvalid <= 1'b1;
            end
        end
    end

    // receiver
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge clk) begin
        t_entry_view got;
        t_entry_view want;
        logic [OP_W-1:0] op;
        in_taken = 1'b0;
        if (rst_n) begin
            quiet_cycles++;
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                results_seen++;
                got.status    = m_tdata[0];
                got.stored    = m_tdata[1];
                got.undeliv   = m_tdata[2];
                got.committed = m_tdata[3];
                got.owned     = m_tdata[4];
                got.owner     = m_tdata[8:5];
                if (expected_views.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result beat %h", m_tdata);
                end else begin
                    want = expected_views.pop_front();
                    if (want.status !== got.status || want.stored !== got.stored ||
                        want.undeliv !== got.undeliv || want.committed !== got.committed ||
                        want.owned !== got.owned || want.owner !== got.owner) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"ERROR: result %0d exp st=%b sto=%b und=%b com=%b",
                                      " own=%b oc=%0d"},
                                     results_seen, want.status, want.stored, want.undeliv,
                                     want.committed, want.owned, want.owner);
                            $display("       got st=%b sto=%b und=%b com=%b own=%b oc=%0d",
                                     got.status, got.stored, got.undeliv, got.committed,
                                     got.owned, got.owner);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                quiet_cycles = 0;
                in_taken = 1'b1;
                op = s_tdata[OP_W-1:0];
                op_count[op]++;
                want = track_op(op, s_tdata[OP_W +: MID_W], s_tdata[OP_W + MID_W +: CID_W]);
                if (want.status) fails_seen++;
                expected_views.push_back(want);
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        src_idle_pct = 34;
        snk_idle_pct = 59;
        hold_req     = 1'b0;
        hold_left    = 0;
        in_taken     = 1'b0;
        quiet_cycles = 0;
        mismatches   = 0;
        results_seen = 0;
        fails_seen   = 0;
        foreach (op_count[k]) op_count[k] = 0;
        foreach (msg_tbl[k]) msg_tbl[k] = '0;
        foreach (client_known[k]) client_known[k] = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, duplicates, missing ids, owner moves, requeue
        add(OP_QUERY,      10'd0,    4'd0);
        add(OP_QUERY,      10'd1023, 4'd15);
        add(OP_INSERT,     10'd0,    4'd0);
        add(OP_INSERT,     10'd0,    4'd0);
        add(OP_INSERT,     10'd1023, 4'd0);
        add(OP_COMMIT,     10'd5,    4'd0);
        add(OP_DELIVER,    10'd7,    4'd15);
        add(OP_DELIVER,    10'd0,    4'd3);
        add(OP_DELIVER,    10'd0,    4'd9);
        add(OP_COMMIT,     10'd0,    4'd0);
        add(OP_QUERY,      10'd0,    4'd0);
        add(OP_DISCONNECT, 10'd0,    4'd3);
        add(OP_QUERY,      10'd0,    4'd0);
        add(OP_DISCONNECT, 10'd0,    4'd3);
        add(OP_DISCONNECT, 10'd1,    4'd12);
        add(OP_INSERT,     10'd682,  4'd0);
        add(OP_DELIVER,    10'd682,  4'd10);
        add(OP_DELIVER,    10'd341,  4'd5);
        add(OP_DISCONNECT, 10'd682,  4'd15);
        add(OP_QUERY,      10'd7,    4'd0);
        add(OP_RSVD_5,     10'd1023, 4'd0);
        add(OP_RSVD_6,     10'd341,  4'd5);
        add(OP_RSVD_7,     10'd682,  4'd10);
        add(OP_COMMIT,     10'd1023, 4'd0);
        add(OP_QUERY,      10'd1023, 4'd0);
        wait_all_done();

        queue_traffic(150);
        wait_all_done();
        queue_traffic(150);
        wait_all_done();

        // long receiver hold while the sender keeps offering
        for (int k = 0; k < 60; k++)
            add(OP_W'($urandom_range(2) == 0 ? OP_QUERY : $urandom_range(2)),
                id_pool[$urandom_range(15)], CID_W'($urandom_range(N_CLIENTS - 1)));
        hold_req = 1'b1;
        wait_all_done();

        src_idle_pct = 59;
        snk_idle_pct = 34;
        queue_traffic(150);
        wait_all_done();
        queue_traffic(150);
        wait_all_done();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_traffic(300);
        wait_all_done();
        repeat (20) @(posedge clk);

        $display({"Covered %0d results: %0d insert, %0d commit, %0d deliver,",
                  " %0d disconnect, %0d query, %0d undefined op"},
                 results_seen, op_count[OP_INSERT], op_count[OP_COMMIT],
                 op_count[OP_DELIVER], op_count[OP_DISCONNECT], op_count[OP_QUERY],
                 op_count[OP_RSVD_5] + op_count[OP_RSVD_6] + op_count[OP_RSVD_7]);
        $display("%0d ops reported failure; %0d mismatches", fails_seen, mismatches);
        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mdt_pkg.sv
rtl/core/mdt_ctrl.sv
rtl/core/mdt_dp.sv
rtl/core/message_delivery_tracker_top.sv
tb/message_delivery_tracker_top_tb.sv
